### src/i2c_mbe_pkg.sv
package i2c_mbe_pkg;

	// bus frame geometry
	localparam int unsigned BITS_PER_BYTE = 8;
	localparam int unsigned BIT_CNT_W     = $clog2(BITS_PER_BYTE);
	localparam int unsigned DELAY_W       = 16;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd10;
	localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BITS_PER_BYTE - 1);

	// operation codes of the request
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_WRITE = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;
	localparam logic [2:0] OP_WAIT  = 3'd5;
	localparam logic [2:0] OP_ACK   = 3'd6;
	localparam logic [2:0] OP_NACK  = 3'd7;

	// running command, one-hot
	typedef enum logic [7:0] {
		CMD_IDLE  = 8'b0000_0001,
		CMD_START = 8'b0000_0010,
		CMD_STOP  = 8'b0000_0100,
		CMD_WRITE = 8'b0000_1000,
		CMD_READ  = 8'b0001_0000,
		CMD_WAIT  = 8'b0010_0000,
		CMD_ACK   = 8'b0100_0000,
		CMD_NACK  = 8'b1000_0000
	} cmd_state_t;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] write_byte;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_missing;
		logic       rejected;
	} out_item_t;

endpackage

### src/i2c_master_bit_engine_core.sv
// I2C master line sequencer.
// in channel (in_valid/in_ready/in_data): one request per bus timing tick, carrying
// the command code, the byte to send and the sampled SDA level of that tick.
// out channel (out_valid/out_ready/out_data): one result per request, giving the
// SCL/SDA drives (1 = released), busy, the done pulse, the last byte read, the
// missing-ack flag and the rejected flag for a command issued while busy.
// cfg_write_en/cfg_write_data: writes delay_ticks, the ticks each phase is held
// (0 acts as 1). Each new phase loads the value held at that tick.
// The result of a request is in the output register the cycle after it is taken.
// Throughput is one request per cycle while out_ready is high; the whole tick
// update is one pass of logic between the state registers and the output register.
// When the receiver stalls, the output register holds its result and in_ready
// drops until that result is taken; a new request is taken in the same cycle the
// held result leaves.
// Reset: idle, both lines released, delay_ticks 10, read byte and ack flag zero,
// output register empty.
module i2c_master_bit_engine_core
	import i2c_mbe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_data,
	input  logic                cfg_write_en,
	input  logic [DELAY_W-1:0]  cfg_write_data
);

	logic [DELAY_W-1:0]   delay_ticks_q;
	cmd_state_t           cmd_q;
	logic [2:0]           phase_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic [DELAY_W-1:0]   delay_cnt_q;
	logic [7:0]           shift_q;
	logic                 scl_q;
	logic                 sda_q;
	logic                 ack_q;
	logic [7:0]           last_read_q;
	out_item_t            out_q;
	logic                 out_valid_q;

	cmd_state_t           cmd_d;
	logic [2:0]           phase_d;
	logic [BIT_CNT_W-1:0] bit_cnt_d;
	logic [DELAY_W-1:0]   delay_cnt_d;
	logic [7:0]           shift_d;
	logic                 scl_d;
	logic                 sda_d;
	logic                 ack_d;
	logic [7:0]           last_read_d;
	logic                 done_d;
	logic                 rej_d;

	cmd_state_t           cmd_use;
	logic [2:0]           ph;
	logic [BIT_CNT_W-1:0] bc;
	logic [7:0]           shift_base;
	logic                 enter;
	logic                 fin;
	logic [DELAY_W-1:0]   delay_load;
	logic                 take;

	// handshake: output register frees up when empty or being drained
	assign in_ready  = !out_valid_q || out_ready;
	assign take      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign delay_load = (delay_ticks_q == '0) ? DELAY_W'(1) : delay_ticks_q;

	// pick the phase to enter this tick: next phase of the running command,
	// or the first phase of a newly issued one
	always_comb begin
		cmd_use    = cmd_q;
		ph         = phase_q;
		bc         = bit_cnt_q;
		shift_base = shift_q;
		enter      = 1'b0;
		rej_d      = 1'b0;
		delay_cnt_d = delay_cnt_q;
		if (cmd_q != CMD_IDLE) begin
			rej_d = (in_data.operation != OP_NONE);
			if (delay_cnt_q > DELAY_W'(1)) begin
				delay_cnt_d = delay_cnt_q - DELAY_W'(1);
			end else begin
				enter = 1'b1;
				if (cmd_q == CMD_WRITE && phase_q == 3'd2) begin
					if (bit_cnt_q != LAST_BIT) begin
						bc = bit_cnt_q + BIT_CNT_W'(1);
						ph = 3'd0;
					end else begin
						ph = 3'd3;
					end
				end else if (cmd_q == CMD_READ && phase_q == 3'd1) begin
					if (bit_cnt_q != LAST_BIT) begin
						bc = bit_cnt_q + BIT_CNT_W'(1);
						ph = 3'd0;
					end else begin
						ph = 3'd2;
					end
				end else begin
					ph = phase_q + 3'd1;
				end
			end
		end else if (in_data.operation != OP_NONE) begin
			enter = 1'b1;
			ph    = 3'd0;
			bc    = '0;
			unique case (in_data.operation)
				OP_START: cmd_use = CMD_START;
				OP_STOP:  cmd_use = CMD_STOP;
				OP_WRITE: cmd_use = CMD_WRITE;
				OP_READ:  cmd_use = CMD_READ;
				OP_WAIT:  cmd_use = CMD_WAIT;
				OP_ACK:   cmd_use = CMD_ACK;
				OP_NACK:  cmd_use = CMD_NACK;
				default:  cmd_use = CMD_IDLE;
			endcase
			if (in_data.operation == OP_WRITE) begin
				shift_base = in_data.write_byte;
			end else if (in_data.operation == OP_READ) begin
				shift_base = '0;
			end
		end
	end

	// line actions of the entered phase
	always_comb begin
		cmd_d       = cmd_q;
		phase_d     = phase_q;
		bit_cnt_d   = bit_cnt_q;
		shift_d     = shift_base;
		scl_d       = scl_q;
		sda_d       = sda_q;
		ack_d       = ack_q;
		last_read_d = last_read_q;
		fin         = 1'b0;
		if (enter) begin
			unique case (cmd_use)
				CMD_START: begin
					if (ph == 3'd0) begin
						scl_d = 1'b1;
						sda_d = 1'b1;
					end else if (ph == 3'd1) begin
						sda_d = 1'b0;
					end else if (ph == 3'd2) begin
						scl_d = 1'b0;
					end else begin
						fin = 1'b1;
					end
				end
				CMD_STOP: begin
					if (ph == 3'd0) begin
						sda_d = 1'b0;
						scl_d = 1'b1;
					end else begin
						sda_d = 1'b1;
						fin   = 1'b1;
					end
				end
				CMD_WRITE: begin
					if (ph == 3'd0) begin
						sda_d = shift_base[7];
					end else if (ph == 3'd1) begin
						scl_d = 1'b1;
					end else if (ph == 3'd2) begin
						scl_d = 1'b0;
						if (bc == LAST_BIT) sda_d = 1'b1;
						shift_d = {shift_base[6:0], 1'b0};
					end else begin
						fin = 1'b1;
					end
				end
				CMD_READ: begin
					if (ph == 3'd0) begin
						shift_d = {shift_base[6:0], 1'b0};
						scl_d   = 1'b1;
					end else if (ph == 3'd1) begin
						shift_d = {shift_base[7:1], shift_base[0] | in_data.sda_in};
						scl_d   = 1'b0;
					end else begin
						last_read_d = shift_base;
						fin         = 1'b1;
					end
				end
				CMD_WAIT: begin
					if (ph == 3'd0) begin
						sda_d = 1'b1;
					end else if (ph == 3'd1) begin
						scl_d = 1'b1;
					end else if (ph == 3'd2) begin
						ack_d = in_data.sda_in;
						scl_d = 1'b0;
					end else begin
						fin = 1'b1;
					end
				end
				CMD_ACK: begin
					if (ph == 3'd0) begin
						sda_d = 1'b0;
					end else if (ph == 3'd1) begin
						scl_d = 1'b1;
					end else if (ph == 3'd2) begin
						scl_d = 1'b0;
					end else begin
						sda_d = 1'b1;
						fin   = 1'b1;
					end
				end
				CMD_NACK: begin
					if (ph == 3'd0) begin
						sda_d = 1'b1;
					end else if (ph == 3'd1) begin
						scl_d = 1'b1;
					end else if (ph == 3'd2) begin
						scl_d = 1'b0;
					end else begin
						fin = 1'b1;
					end
				end
				default: begin
					fin = 1'b1;
				end
			endcase
			if (fin) begin
				cmd_d     = CMD_IDLE;
				phase_d   = 3'd0;
				bit_cnt_d = '0;
			end else begin
				cmd_d     = cmd_use;
				phase_d   = ph;
				bit_cnt_d = bc;
			end
		end
		done_d = fin;
	end

	// delay register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_ticks_q <= DELAY_RESET;
		end else if (cfg_write_en) begin
			delay_ticks_q <= cfg_write_data;
		end
	end

	// sequencer state, advanced once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q       <= CMD_IDLE;
			phase_q     <= 3'd0;
			bit_cnt_q   <= '0;
			delay_cnt_q <= '0;
			shift_q     <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			ack_q       <= 1'b0;
			last_read_q <= '0;
		end else if (take) begin
			cmd_q       <= cmd_d;
			phase_q     <= phase_d;
			bit_cnt_q   <= bit_cnt_d;
			delay_cnt_q <= enter ? (fin ? '0 : delay_load) : delay_cnt_d;
			shift_q     <= shift_d;
			scl_q       <= scl_d;
			sda_q       <= sda_d;
			ack_q       <= ack_d;
			last_read_q <= last_read_d;
		end
	end

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (take) begin
			out_q.scl_out     <= scl_d;
			out_q.sda_out     <= sda_d;
			out_q.busy_res    <= (cmd_d != CMD_IDLE);
			out_q.done_res    <= done_d;
			out_q.read_data   <= last_read_d;
			out_q.ack_missing <= ack_d;
			out_q.rejected    <= rej_d;
		end
	end

endmodule
